// ===== rtl/core/qdsc_pkg.sv =====
`timescale 1ns / 1ps

package qdsc_pkg;

	// cursor row width
	localparam int ROW_BITS = 10;
	localparam logic [ROW_BITS-1:0] ROW_LIMIT = {ROW_BITS{1'b1}};

	// field widths
	localparam int FUNC_W  = 2;
	localparam int STEP_W  = 8;
	localparam int GAIN_W  = 4;
	localparam int ROWS_W  = 11;
	localparam int CIDX_W  = 1;
	localparam int PROD_W  = STEP_W + GAIN_W + 1;
	localparam int SUM_W   = ((ROW_BITS + 1 > PROD_W) ? ROW_BITS + 1 : PROD_W) + 1;
	localparam int CMP_W   = (SUM_W > ROWS_W) ? SUM_W : ROWS_W;

	// pending count limits
	localparam logic signed [STEP_W-1:0] STEP_MAX = STEP_W'(127);
	localparam logic signed [STEP_W-1:0] STEP_MIN = -STEP_W'(127);

	// item function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_CLICK  = 2'd1,
		FUNC_POLL   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_STEP_GAIN   = 1'b0;
	localparam logic [CIDX_W-1:0] REG_SCREEN_ROWS = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(480);

	// decoder table entry: [5:4] direction, [2:0] next state
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_CW   = 2'b01;
	localparam logic [1:0] DIR_CCW  = 2'b10;

	localparam logic [5:0] QUAD_TABLE [0:7][0:3] = '{
		'{6'h00, 6'h02, 6'h04, 6'h00},
		'{6'h03, 6'h00, 6'h01, 6'h10},
		'{6'h03, 6'h02, 6'h00, 6'h00},
		'{6'h03, 6'h02, 6'h01, 6'h00},
		'{6'h06, 6'h00, 6'h04, 6'h00},
		'{6'h06, 6'h05, 6'h00, 6'h20},
		'{6'h06, 6'h05, 6'h04, 6'h00},
		'{6'h00, 6'h02, 6'h04, 6'h00}
	};

	// control from top level to the detent counter
	typedef struct packed {
		logic sample;
		logic poll;
		logic pin_a;
		logic pin_b;
	} quad_ctl_t;

endpackage

// ===== rtl/core/qdsc_if.sv =====
`timescale 1ns / 1ps

// input item channel
interface qdsc_in_if;
	logic                        valid;
	logic                        ready;
	logic [qdsc_pkg::FUNC_W-1:0] func;
	logic                        pin_a;
	logic                        pin_b;

	modport source (output valid, output func, output pin_a, output pin_b, input ready);
	modport sink   (input valid, input func, input pin_a, input pin_b, output ready);
endinterface

// result channel
interface qdsc_out_if;
	logic                                valid;
	logic                                ready;
	logic [qdsc_pkg::ROW_BITS-1:0]       cursor_y;
	logic signed [qdsc_pkg::STEP_W-1:0]  step_delta;
	logic                                was_clicked;
	logic                                moved;

	modport source (output valid, output cursor_y, output step_delta, output was_clicked,
		output moved, input ready);
	modport sink   (input valid, input cursor_y, input step_delta, input was_clicked,
		input moved, output ready);
endinterface

// configuration write channel
interface qdsc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [qdsc_pkg::CIDX_W-1:0] index;
	logic [qdsc_pkg::ROWS_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/quadrature_detent_scroll_cursor.sv =====
`timescale 1ns / 1ps
// a poll beat's result is registered and shows in the cycle after the beat is accepted
// throughput: one input beat per cycle; sample and click beats give no result
// the input stalls only while a result is held and its sink is not ready
// arst_n clears decoder state, pending count, click flag, cursor row and result valid,
// and sets step_gain to 1 and screen_rows to 480

module quadrature_detent_scroll_cursor (
	input  logic             clk,
	input  logic             arst_n,
	qdsc_in_if.sink          item,
	qdsc_out_if.source       result,
	qdsc_cfg_if.sink         cfg
);

	logic [qdsc_pkg::GAIN_W-1:0]         step_gain_q;
	logic [qdsc_pkg::ROWS_W-1:0]         screen_rows_q;
	logic                                click_q;
	logic [qdsc_pkg::ROW_BITS-1:0]       cursor_row_q;
	logic                                out_valid_q;
	logic [qdsc_pkg::ROW_BITS-1:0]       cursor_y_q;
	logic signed [qdsc_pkg::STEP_W-1:0]  step_delta_q;
	logic                                was_clicked_q;
	logic                                moved_q;

	logic                                accept;
	qdsc_pkg::quad_ctl_t                 ctl;
	logic signed [qdsc_pkg::STEP_W-1:0]  pending;
	logic signed [qdsc_pkg::PROD_W-1:0]  prod;
	logic signed [qdsc_pkg::SUM_W-1:0]   row_sum;
	logic [qdsc_pkg::ROWS_W-1:0]         rows_top;
	logic [qdsc_pkg::CMP_W-1:0]          top_ext;
	logic [qdsc_pkg::CMP_W-1:0]          top;
	logic [qdsc_pkg::ROW_BITS-1:0]       row_next;

	// handshakes
	assign item.ready = !out_valid_q || result.ready;
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;

	always_comb begin
		ctl.sample = accept && (item.func == qdsc_pkg::FUNC_SAMPLE);
		ctl.poll   = accept && (item.func == qdsc_pkg::FUNC_POLL);
		ctl.pin_a  = item.pin_a;
		ctl.pin_b  = item.pin_b;
	end

	qdsc_quad u_quad (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.pending (pending)
	);

	// cursor move and clamp
	always_comb begin
		prod     = qdsc_pkg::PROD_W'(pending) * $signed({1'b0, step_gain_q});
		row_sum  = $signed(qdsc_pkg::SUM_W'(cursor_row_q)) + qdsc_pkg::SUM_W'(prod);
		rows_top = (screen_rows_q == '0) ? '0 : screen_rows_q - qdsc_pkg::ROWS_W'(1);
		top_ext  = qdsc_pkg::CMP_W'(rows_top);
		top      = (top_ext > qdsc_pkg::CMP_W'(qdsc_pkg::ROW_LIMIT))
			? qdsc_pkg::CMP_W'(qdsc_pkg::ROW_LIMIT) : top_ext;
		if (row_sum < 0) begin
			row_next = '0;
		end else if (qdsc_pkg::CMP_W'(row_sum) > top) begin
			row_next = top[qdsc_pkg::ROW_BITS-1:0];
		end else begin
			row_next = row_sum[qdsc_pkg::ROW_BITS-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_gain_q   <= qdsc_pkg::GAIN_RESET;
			screen_rows_q <= qdsc_pkg::ROWS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				qdsc_pkg::REG_STEP_GAIN:   step_gain_q   <= cfg.data[qdsc_pkg::GAIN_W-1:0];
				qdsc_pkg::REG_SCREEN_ROWS: screen_rows_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// click flag and cursor row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_q      <= 1'b0;
			cursor_row_q <= '0;
		end else if (accept && item.func == qdsc_pkg::FUNC_CLICK) begin
			click_q <= 1'b1;
		end else if (ctl.poll) begin
			click_q      <= 1'b0;
			cursor_row_q <= row_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.poll) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.poll) begin
			cursor_y_q    <= row_next;
			step_delta_q  <= pending;
			was_clicked_q <= click_q;
			moved_q       <= (pending != '0);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.cursor_y    = cursor_y_q;
	assign result.step_delta  = step_delta_q;
	assign result.was_clicked = was_clicked_q;
	assign result.moved       = moved_q;

endmodule

// ===== rtl/core/qdsc_quad.sv =====
`timescale 1ns / 1ps

module qdsc_quad (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qdsc_pkg::quad_ctl_t               ctl,
	output logic signed [qdsc_pkg::STEP_W-1:0] pending
);

	logic [2:0]                         quad_state_q;
	logic signed [qdsc_pkg::STEP_W-1:0] pending_q;
	logic [5:0]                         entry;
	logic [1:0]                         dir;

	// table walk on packed pins
	always_comb begin
		entry = qdsc_pkg::QUAD_TABLE[quad_state_q][{ctl.pin_b, ctl.pin_a}];
		dir   = entry[5:4];
	end

	// machine state and saturating detent count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_state_q <= 3'd0;
			pending_q    <= '0;
		end else if (ctl.sample) begin
			quad_state_q <= entry[2:0];
			if (dir == qdsc_pkg::DIR_CW && pending_q != qdsc_pkg::STEP_MAX) begin
				pending_q <= pending_q + qdsc_pkg::STEP_W'(1);
			end else if (dir == qdsc_pkg::DIR_CCW && pending_q != qdsc_pkg::STEP_MIN) begin
				pending_q <= pending_q - qdsc_pkg::STEP_W'(1);
			end
		end else if (ctl.poll) begin
			pending_q <= '0;
		end
	end

	assign pending = pending_q;

endmodule

// ===== rtl/core/qdsc_checker.sv =====
`timescale 1ns / 1ps

module qdsc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic [qdsc_pkg::FUNC_W-1:0]        item_func,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic [qdsc_pkg::ROW_BITS-1:0]      res_cursor_y,
	input logic signed [qdsc_pkg::STEP_W-1:0] res_step_delta,
	input logic                               res_moved
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_cursor_y)
			&& $stable(res_step_delta))
		else $error("stalled result beat changed");

	// poll beat gives a result next cycle
	a_poll: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_func == qdsc_pkg::FUNC_POLL |=> res_valid)
		else $error("poll beat gave no result");

	// other beats create no result
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !(item_valid && item_ready && item_func == qdsc_pkg::FUNC_POLL)
			|=> !res_valid)
		else $error("result without poll beat");

	// moved flag matches delta
	a_moved: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_moved == (res_step_delta != '0))
		else $error("moved flag disagrees with delta");

	// count saturates short of the most negative code
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_step_delta != -qdsc_pkg::STEP_W'(128))
		else $error("step delta out of range");

endmodule

bind quadrature_detent_scroll_cursor qdsc_checker u_qdsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_func      (item.func),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_cursor_y   (result.cursor_y),
	.res_step_delta (result.step_delta),
	.res_moved      (result.moved)
);

// ===== tb/tb_quadrature_detent_scroll_cursor.sv =====
`timescale 1ns / 1ps

module tb_quadrature_detent_scroll_cursor;

	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 100;
	localparam int RANDOM_POLLS = 15;

	// decoder transitions: [5:4] direction, [2:0] next state, indexed by state and {b, a}
	localparam logic [5:0] DETENT_NEXT [0:7][0:3] = '{
		'{6'h00, 6'h02, 6'h04, 6'h00},
		'{6'h03, 6'h00, 6'h01, 6'h10},
		'{6'h03, 6'h02, 6'h00, 6'h00},
		'{6'h03, 6'h02, 6'h01, 6'h00},
		'{6'h06, 6'h00, 6'h04, 6'h00},
		'{6'h06, 6'h05, 6'h00, 6'h20},
		'{6'h06, 6'h05, 6'h04, 6'h00},
		'{6'h00, 6'h02, 6'h04, 6'h00}
	};

	// pin columns {b, a} of one full detent
	localparam logic [1:0] CW_COLS [0:3] = '{2'd1, 2'd0, 2'd2, 2'd3};
	localparam logic [1:0] CCW_COLS [0:3] = '{2'd2, 2'd0, 2'd1, 2'd3};

	typedef struct packed {
		logic [qdsc_pkg::ROW_BITS-1:0]      cursor_y;
		logic signed [qdsc_pkg::STEP_W-1:0] step_delta;
		logic                               was_clicked;
		logic                               moved;
	} poll_report_t;

	// cursor predictor and store of poll reports still to arrive
	class scroll_scoreboard;
		logic [2:0]                         quad_state;
		logic signed [qdsc_pkg::STEP_W-1:0] pending;
		logic                               click_flag;
		logic [qdsc_pkg::ROW_BITS-1:0]      row;
		logic [qdsc_pkg::GAIN_W-1:0]        gain;
		logic [qdsc_pkg::ROWS_W-1:0]        rows;
		poll_report_t                       reports_due[$];
		int                                 mismatches;

		function new();
			quad_state = 3'd0;
			pending = '0;
			click_flag = 1'b0;
			row = '0;
			gain = qdsc_pkg::GAIN_RESET;
			rows = qdsc_pkg::ROWS_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [qdsc_pkg::CIDX_W-1:0] index,
				logic [qdsc_pkg::ROWS_W-1:0] data);
			case (index)
				qdsc_pkg::REG_STEP_GAIN: gain = data[qdsc_pkg::GAIN_W-1:0];
				qdsc_pkg::REG_SCREEN_ROWS: rows = data;
				default: ;
			endcase
		endfunction

		function void take_item(qdsc_pkg::func_t f, logic a, logic b);
			logic [5:0] entry;
			int moved_row;
			int top;
			poll_report_t rep;
			case (f)
				qdsc_pkg::FUNC_SAMPLE: begin
					entry = DETENT_NEXT[quad_state][{b, a}];
					quad_state = entry[2:0];
					if (entry[5:4] == qdsc_pkg::DIR_CW && pending != qdsc_pkg::STEP_MAX)
						pending = pending + 8'sd1;
					else if (entry[5:4] == qdsc_pkg::DIR_CCW && pending != qdsc_pkg::STEP_MIN)
						pending = pending - 8'sd1;
				end
				qdsc_pkg::FUNC_CLICK: click_flag = 1'b1;
				qdsc_pkg::FUNC_POLL: begin
					moved_row = int'(row) + int'(pending) * int'(gain);
					// zero rows behaves as one, wide screens clamp to the row range
					top = (rows == '0) ? 0 : int'(rows) - 1;
					if (top > int'(qdsc_pkg::ROW_LIMIT))
						top = int'(qdsc_pkg::ROW_LIMIT);
					if (moved_row < 0)
						moved_row = 0;
					if (moved_row > top)
						moved_row = top;
					row = moved_row[qdsc_pkg::ROW_BITS-1:0];
					rep.cursor_y = row;
					rep.step_delta = pending;
					rep.was_clicked = click_flag;
					rep.moved = (pending != '0);
					reports_due.push_back(rep);
					pending = '0;
					click_flag = 1'b0;
				end
				default: ;
			endcase
		endfunction

		function void check_report(poll_report_t got);
			poll_report_t want;
			if (reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected poll beat y=%0d delta=%0d click=%0b moved=%0b",
						$time, got.cursor_y, got.step_delta, got.was_clicked, got.moved);
				return;
			end
			want = reports_due.pop_front();
			if (got.cursor_y !== want.cursor_y || got.step_delta !== want.step_delta ||
					got.was_clicked !== want.was_clicked || got.moved !== want.moved) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t poll mismatch exp y=%0d delta=%0d click=%0b moved=%0b,",
						" got y=%0d delta=%0d click=%0b moved=%0b"},
						$time, want.cursor_y, want.step_delta, want.was_clicked, want.moved,
						got.cursor_y, got.step_delta, got.was_clicked, got.moved);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   items_sent;
	int   polls_sent;

	scroll_scoreboard sb = new();

	qdsc_in_if  item_ch ();
	qdsc_out_if result_ch ();
	qdsc_cfg_if cfg_ch ();

	quadrature_detent_scroll_cursor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.sink),
		.cfg    (cfg_ch.sink)
	);

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// input beat: optional gap with valid low, then hold until accepted
	task automatic send_item(input qdsc_pkg::func_t f, input logic a, input logic b);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.pin_a <= a;
		item_ch.pin_b <= b;
		do @(posedge clk); while (!item_ch.ready);
		sb.take_item(f, a, b);
		if (f != qdsc_pkg::FUNC_NONE)
			items_sent++;
		if (f == qdsc_pkg::FUNC_POLL)
			polls_sent++;
	endtask

	// one full detent, with an optional repeated sample as contact bounce
	task automatic turn_detent(input bit ccw, input bit bounce);
		logic [1:0] col;
		for (int k = 0; k < 4; k++) begin
			col = ccw ? CCW_COLS[k] : CW_COLS[k];
			send_item(qdsc_pkg::FUNC_SAMPLE, col[0], col[1]);
			if (bounce && $urandom_range(0, 3) == 0)
				send_item(qdsc_pkg::FUNC_SAMPLE, col[0], col[1]);
		end
	endtask

	// stop sending and wait for every poll report to come back
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (sb.reports_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic set_register(input logic [qdsc_pkg::CIDX_W-1:0] index,
			input logic [qdsc_pkg::ROWS_W-1:0] data);
		repeat (3) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(index, data);
		cfg_ch.valid <= 1'b0;
	endtask

	// result sink with random stalls
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.check_report('{result_ch.cursor_y, result_ch.step_delta,
				result_ch.was_clicked, result_ch.moved});
		end
	end

	// watchdog on cycles with no beat on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) ||
					(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// stimulus
	initial begin
		int pick;
		int chunks;
		int rows_pick;
		int random_start;
		int poll_start;
		logic [qdsc_pkg::ROWS_W-1:0] rows_val;

		arst_n = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		polls_sent = 0;
		item_ch.valid = 1'b0;
		item_ch.func = qdsc_pkg::FUNC_SAMPLE;
		item_ch.pin_a = 1'b0;
		item_ch.pin_b = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = qdsc_pkg::REG_STEP_GAIN;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset poll, one detent clockwise and two back, click, ignored code, broken sequence
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		turn_detent(1'b0, 1'b0);
		send_item(qdsc_pkg::FUNC_CLICK, 1'b1, 1'b1);
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		turn_detent(1'b1, 1'b0);
		turn_detent(1'b1, 1'b0);
		send_item(qdsc_pkg::FUNC_NONE, 1'b1, 1'b1);
		send_item(qdsc_pkg::FUNC_POLL, 1'b1, 1'b1);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b1, 1'b1);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b0, 1'b1);
		send_item(qdsc_pkg::FUNC_SAMPLE, 1'b1, 1'b1);
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		settle();

		// saturation of the pending count, with top gain and an oversized screen
		set_register(qdsc_pkg::REG_STEP_GAIN, qdsc_pkg::ROWS_W'(15));
		set_register(qdsc_pkg::REG_SCREEN_ROWS, qdsc_pkg::ROWS_W'(2047));
		calm = 1'b1;
		repeat (128) turn_detent(1'b0, 1'b0);
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		calm = 1'b0;
		settle();

		// zero screen rows holds the cursor at the top, zero gain never moves it
		set_register(qdsc_pkg::REG_SCREEN_ROWS, qdsc_pkg::ROWS_W'(0));
		set_register(qdsc_pkg::REG_STEP_GAIN, qdsc_pkg::ROWS_W'(3));
		turn_detent(1'b0, 1'b1);
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		settle();
		set_register(qdsc_pkg::REG_SCREEN_ROWS, qdsc_pkg::ROWS_W'(1024));
		set_register(qdsc_pkg::REG_STEP_GAIN, qdsc_pkg::ROWS_W'(0));
		turn_detent(1'b0, 1'b0);
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		settle();
		set_register(qdsc_pkg::REG_SCREEN_ROWS, qdsc_pkg::ROWS_W'(1));
		turn_detent(1'b0, 1'b0);
		send_item(qdsc_pkg::FUNC_POLL, 1'b0, 1'b0);
		settle();

		// random phases: new settings, then mostly clean detents with noise mixed in
		random_start = items_sent;
		poll_start = polls_sent;
		while (items_sent - random_start < RANDOM_ITEMS ||
				polls_sent - poll_start < RANDOM_POLLS) begin
			set_register(qdsc_pkg::REG_STEP_GAIN, qdsc_pkg::ROWS_W'($urandom_range(0, 15)));
			rows_pick = $urandom_range(0, 7);
			case (rows_pick)
				0: rows_val = qdsc_pkg::ROWS_W'(0);
				1: rows_val = qdsc_pkg::ROWS_W'(1);
				2: rows_val = qdsc_pkg::ROWS_W'(1024);
				3: rows_val = qdsc_pkg::ROWS_W'(2047);
				4: rows_val = qdsc_pkg::ROWS_W'($urandom_range(0, 2047));
				default: rows_val = qdsc_pkg::ROWS_W'($urandom_range(2, 600));
			endcase
			set_register(qdsc_pkg::REG_SCREEN_ROWS, rows_val);
			calm = ($urandom_range(0, 3) == 0);
			chunks = $urandom_range(8, 20);
			repeat (chunks) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					repeat ($urandom_range(1, 4))
						turn_detent(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else if (pick < 62)
					send_item(qdsc_pkg::FUNC_SAMPLE, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else if (pick < 72)
					send_item(qdsc_pkg::FUNC_CLICK, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else if (pick < 95)
					send_item(qdsc_pkg::FUNC_POLL, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					send_item(qdsc_pkg::FUNC_NONE, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
			calm = 1'b0;
			settle();
		end

		if (sb.mismatches == 0 && sb.reports_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/qdsc_pkg.sv
rtl/core/qdsc_if.sv
rtl/core/qdsc_quad.sv
rtl/core/quadrature_detent_scroll_cursor.sv
rtl/core/qdsc_checker.sv
tb/tb_quadrature_detent_scroll_cursor.sv
